### sv/assert_macros.svh
// Assertion macros for the RTL; they expand to nothing in synthesis.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define AST_PROP(lbl, prop, msg)
`define AST_IMPL(lbl, ante, cons, msg)
`endif
`endif

### sv/ssym_pkg.sv
package ssym_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int NAME_BYTES_DEF  = 8;
    localparam int SCOPE_W         = 9;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_TRUNC  = 2'd2
    } action_t;

    typedef struct packed {
        logic               status;
        logic               found;
        logic [7:0]         entry_index;
        logic [15:0]        found_class;
        logic signed [15:0] found_offset;
    } ssym_result_t;

    // Zero every byte after the first zero byte.
    function automatic logic [63:0] canon_name(input logic [63:0] raw);
        logic [63:0] res;
        logic        alive;
        res   = '0;
        alive = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            alive = alive && (raw[8*k +: 8] != 8'd0);
            res[8*k +: 8] = alive ? raw[8*k +: 8] : 8'd0;
        end
        return res;
    endfunction

endpackage

### sv/ssym_ram.sv
module ssym_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/ssym_engine.sv
`include "assert_macros.svh"
module ssym_engine #(
    parameter int TABLE_DEPTH = ssym_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_BYTES  = ssym_pkg::NAME_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [63:0]                  name_chars,
    input  logic                         name_overlong,
    input  logic [15:0]                  symbol_class,
    input  logic signed [15:0]           symbol_offset,
    input  logic [ssym_pkg::SCOPE_W-1:0] scope_start,
    output logic                         res_valid,
    input  logic                         res_ready,
    output ssym_pkg::ssym_result_t       res
);
    import ssym_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int NW   = 8 * NAME_BYTES;
    localparam int MW   = NW + 32;
    localparam int CMPW = (CW > SCOPE_W) ? CW : SCOPE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t       state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [NW-1:0] name_reg, name_next;
    ssym_result_t res_reg, res_next;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [MW-1:0] ram_wdata;
    logic [MW-1:0] ram_rdata;
    logic [63:0]   in_canon;
    logic [63:0]   in_high;
    logic          lookup_ok;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] idx_m1;

    function automatic logic [7:0] to_idx8(input logic [AW-1:0] x);
        logic [AW+7:0] ext;
        ext = {8'd0, x};
        return ext[7:0];
    endfunction

    assign in_canon  = canon_name(name_chars);
    assign in_high   = in_canon >> NW;
    assign lookup_ok = !name_overlong && (in_high == 64'd0);
    assign cnt_m1    = count_reg - CW'(1);
    assign idx_m1    = idx_reg - AW'(1);
    assign ram_wdata = {in_canon[NW-1:0], symbol_class, symbol_offset};
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    ssym_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        name_next  = name_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_raddr  = (state_reg == S_SCAN) ? idx_m1 : cnt_m1[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next   = '0;
                    state_next = S_RESULT;
                    unique case (action)
                        ACT_LOOKUP:
                        begin
                            name_next = in_canon[NW-1:0];
                            if (lookup_ok && (count_reg != '0))
                            begin
                                idx_next   = cnt_m1[AW-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        ACT_ADD:
                        begin
                            if (count_reg >= CW'(TABLE_DEPTH))
                            begin
                                res_next.status = 1'b1;
                            end
                            else
                            begin
                                ram_we               = 1'b1;
                                res_next.entry_index = to_idx8(count_reg[AW-1:0]);
                                count_next           = count_reg + CW'(1);
                            end
                        end
                        ACT_TRUNC:
                        begin
                            if (CMPW'(scope_start) <= CMPW'(count_reg))
                            begin
                                count_next = CW'(scope_start);
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // ram_rdata holds the entry at idx_reg
                if (ram_rdata[MW-1 -: NW] == name_reg)
                begin
                    res_next.found        = 1'b1;
                    res_next.entry_index  = to_idx8(idx_reg);
                    res_next.found_class  = ram_rdata[31:16];
                    res_next.found_offset = ram_rdata[15:0];
                    state_next            = S_RESULT;
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    idx_next = idx_m1;
                end
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        name_reg <= name_next;
        res_reg  <= res_next;
    end

    `AST_PROP(a_count_bound, count_reg <= CW'(TABLE_DEPTH), "entry count above depth")
    `AST_IMPL(a_write_room, ram_we, count_reg < CW'(TABLE_DEPTH), "write into full table")
    `AST_IMPL(a_scan_range, state_reg == S_SCAN, CW'(idx_reg) < count_reg, "scan past count")
    `AST_IMPL(a_count_idle, count_next != count_reg, state_reg == S_IDLE && in_valid, "count moved outside accept")

endmodule

### sv/scoped_symbol_table.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------------
// input     | in_valid / in_ready  | action, name_chars, name_overlong,
//           |                      | symbol_class, symbol_offset
// result    | out_valid / out_ready| status, found, entry_index, found_class,
//           |                      | found_offset
// config    | cfg_wr_en            | cfg_wr_data (scope_start)
//
// Add, truncate and unused actions load the engine result register on accept; its
// handoff to the output register frees the input. A lookup first scans entries,
// newest first, up to the entry count (at most TABLE_DEPTH), one table RAM read per cycle.
// Reset clears the entry count and scope start; the RAM needs no clearing pass.
// One transaction is in flight at a time; a result held in the output register
// lets the next one start and stalls only the handoff after it.
module scoped_symbol_table #(
    parameter int TABLE_DEPTH = ssym_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_BYTES  = ssym_pkg::NAME_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [63:0]                  name_chars,
    input  logic                         name_overlong,
    input  logic [15:0]                  symbol_class,
    input  logic signed [15:0]           symbol_offset,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         status,
    output logic                         found,
    output logic [7:0]                   entry_index,
    output logic [15:0]                  found_class,
    output logic signed [15:0]           found_offset,
    input  logic                         cfg_wr_en,
    input  logic [ssym_pkg::SCOPE_W-1:0] cfg_wr_data
);
    import ssym_pkg::*;

    logic [SCOPE_W-1:0] scope_start_reg;
    logic               out_valid_reg;
    ssym_result_t       out_reg;
    logic               res_valid;
    logic               res_ready;
    ssym_result_t       res;

    // Take a new result when the output register is empty or drains this cycle.
    assign res_ready = !out_valid_reg || out_ready;

    ssym_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .name_chars    (name_chars),
        .name_overlong (name_overlong),
        .symbol_class  (symbol_class),
        .symbol_offset (symbol_offset),
        .scope_start   (scope_start_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // Hold scope start; the user must write it only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scope_start_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            scope_start_reg <= cfg_wr_data;
        end
    end

    // Output register: load on engine handoff, drop on downstream accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign found        = out_reg.found;
    assign entry_index  = out_reg.entry_index;
    assign found_class  = out_reg.found_class;
    assign found_offset = out_reg.found_offset;

endmodule
